FILE: hdl/crls_pkg.sv
// ----------------------------------------------------------------------------
// crls_pkg
// Shared types, constants and the control store of the LCD refresh sequencer.
// ----------------------------------------------------------------------------
package crls_pkg;

  localparam int COLUMNS_DEF = 16;
  localparam logic [7:0] MIN_GAP_RST = 8'd5;

  // Input operation codes.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_REQ   = 2'd2;

  // Expander bit assignments and display commands.
  localparam logic [7:0] BIT_RS    = 8'h01;
  localparam logic [7:0] BIT_EN    = 8'h04;
  localparam logic [7:0] BIT_BL    = 8'h08;
  localparam logic [7:0] CMD_LINE1 = 8'h80;
  localparam logic [7:0] CMD_LINE2 = 8'hC0;
  localparam logic [7:0] NIB_MASK  = 8'hF0;
  localparam logic [7:0] CHR_SPACE = 8'h20;

  // Microcode addresses.
  localparam logic [1:0] UA_WAIT  = 2'd0;
  localparam logic [1:0] UA_CMD   = 2'd1;
  localparam logic [1:0] UA_CHAR  = 2'd2;
  localparam logic [1:0] UA_SPARE = 2'd3;

  // Emit selection of a control word.
  localparam logic [1:0] EM_NONE = 2'd0;
  localparam logic [1:0] EM_CMD  = 2'd1;
  localparam logic [1:0] EM_CHAR = 2'd2;

  // Jump conditions of a control word.
  localparam logic [1:0] J_DISPATCH = 2'd0;
  localparam logic [1:0] J_ON_FREE  = 2'd1;
  localparam logic [1:0] J_LINE_END = 2'd2;
  localparam logic [1:0] J_ALWAYS   = 2'd3;

  typedef struct packed {
    logic       take_in;
    logic [1:0] emit;
    logic [1:0] jcond;
    logic [1:0] jaddr;
  } uword_t;

  // Conditions the datapath reports to the sequencer.
  typedef struct packed {
    logic in_valid;
    logic line_go;
    logic out_free;
    logic col_last;
  } seq_stat_t;

  // Strobes the sequencer hands to the datapath.
  typedef struct packed {
    logic take_in;
    logic load_cmd;
    logic load_char;
  } seq_ctl_t;

  localparam uword_t UCODE [4] = '{
    '{1'b1, EM_NONE, J_DISPATCH, UA_CMD},
    '{1'b0, EM_CMD,  J_ON_FREE,  UA_CHAR},
    '{1'b0, EM_CHAR, J_LINE_END, UA_WAIT},
    '{1'b0, EM_NONE, J_ALWAYS,   UA_WAIT}
  };

  localparam logic [7:0] GREET_ONE [11] = '{
    8'h57, 8'h61, 8'h76, 8'h65, 8'h20, 8'h50, 8'h6C, 8'h61, 8'h79, 8'h65, 8'h72
  };
  localparam logic [7:0] GREET_TWO [5] = '{8'h52, 8'h65, 8'h61, 8'h64, 8'h79};

  // Power-up content of the line store at a flat position.
  function automatic logic [7:0] greet_byte(input int unsigned pos,
                                            input int unsigned cols);
    int unsigned idx;
    logic [7:0]  res;
    res = CHR_SPACE;
    if (pos < cols) begin
      idx = pos;
      if (idx < 11) res = GREET_ONE[idx];
    end else begin
      idx = pos - cols;
      if (idx < 5) res = GREET_TWO[idx];
    end
    return res;
  endfunction

endpackage

FILE: hdl/crls_line_mem.sv
// ----------------------------------------------------------------------------
// crls_line_mem
// Two-line character store with a registered read port; unwritten entries
// read back as the greeting text.
// ----------------------------------------------------------------------------
module crls_line_mem #(
  parameter int COLUMNS = crls_pkg::COLUMNS_DEF,
  parameter int AW      = $clog2(2 * COLUMNS)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);
  import crls_pkg::*;

  localparam int DEPTH = 2 * COLUMNS;

  logic [7:0]    mem [DEPTH];
  logic [DEPTH-1:0] wrt_r;
  logic [7:0]    data_r;
  logic          wrt_q_r;
  logic [AW-1:0] addr_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrt_r <= '0;
    end else if (wr_en) begin
      wrt_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      data_r   <= mem[rd_addr];
      wrt_q_r  <= wrt_r[rd_addr];
      addr_q_r <= rd_addr;
    end
  end

  assign rd_data = wrt_q_r ? data_r
                           : greet_byte(int'(addr_q_r), COLUMNS);

endmodule

FILE: hdl/crls_out_stage.sv
// ----------------------------------------------------------------------------
// crls_out_stage
// Output register that expands one transfer into its six expander bytes.
// ----------------------------------------------------------------------------
module crls_out_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  logic [7:0] value,
  input  logic       is_data,
  input  logic       fin,
  output logic       free,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_hi_setup,
  output logic [7:0] out_hi_strobe,
  output logic [7:0] out_hi_release,
  output logic [7:0] out_lo_setup,
  output logic [7:0] out_lo_strobe,
  output logic [7:0] out_lo_release,
  output logic       out_last
);
  import crls_pkg::*;

  logic       vld_r, vld_nxt;
  logic [7:0] hi_r, lo_r;
  logic       last_r;
  logic [7:0] base;

  assign free = !vld_r || out_ready;
  assign base = BIT_BL | (is_data ? BIT_RS : 8'h00);

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hi_r   <= (value & NIB_MASK) | base;
      lo_r   <= {value[3:0], 4'h0} | base;
      last_r <= fin;
    end
  end

  assign out_valid      = vld_r;
  assign out_hi_setup   = hi_r;
  assign out_hi_strobe  = hi_r | BIT_EN;
  assign out_hi_release = hi_r & ~BIT_EN;
  assign out_lo_setup   = lo_r;
  assign out_lo_strobe  = lo_r | BIT_EN;
  assign out_lo_release = lo_r & ~BIT_EN;
  assign out_last       = last_r;

endmodule

FILE: hdl/crls_sequencer.sv
// ----------------------------------------------------------------------------
// crls_sequencer
// Microprogram counter and control store; turns control words and datapath
// conditions into strobes.
// ----------------------------------------------------------------------------
module crls_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  input  crls_pkg::seq_stat_t stat,
  output crls_pkg::seq_ctl_t  ctl
);
  import crls_pkg::*;

  logic [1:0] upc_r, upc_nxt;
  uword_t     uw;

  assign uw = UCODE[upc_r];

  always_comb begin
    upc_nxt = upc_r;
    case (uw.jcond)
      J_DISPATCH: begin
        if (stat.in_valid && stat.line_go) upc_nxt = uw.jaddr;
      end
      J_ON_FREE: begin
        if (stat.out_free) upc_nxt = uw.jaddr;
      end
      J_LINE_END: begin
        if (stat.out_free && stat.col_last) upc_nxt = uw.jaddr;
      end
      default: begin
        upc_nxt = uw.jaddr;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= UA_WAIT;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  assign ctl.take_in   = uw.take_in;
  assign ctl.load_cmd  = (uw.emit == EM_CMD) && stat.out_free;
  assign ctl.load_char = (uw.emit == EM_CHAR) && stat.out_free;

`ifndef ASSERT_OFF
  a_spare_unused: assert property (@(posedge clk) disable iff (!rst_n)
    upc_r != UA_SPARE)
    else $error("sequencer reached the spare step");
`endif

endmodule

FILE: hdl/char_lcd_refresh_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_refresh_sequencer
// Refreshes a two-line character display through a port expander: keeps the
// line buffers and emits cursor and character transfers on timed ticks.
// ----------------------------------------------------------------------------
//  Channel  Direction  Signals                                Handshake
//  in       input      in_op in_now_ms in_line_sel in_column  in_valid/in_ready
//                      in_char_code
//  out      output     out_hi_* out_lo_* out_last             out_valid/out_ready
//  cfg      input      cfg_min_gap_ms                         cfg_we
//
// A write, a request or a tick that starts no line is accepted with no transfer.
// A tick that starts a line phase is accepted, then sends one transfer per cycle
// while the output register is free (cursor command, then COLUMNS characters),
// paced by the output register and the one read port of the line store.
// The input is not ready while a line phase is being sent; a stalled output
// holds the sequencer in place. Reset is synchronous, with no clearing pass.
// ----------------------------------------------------------------------------
module char_lcd_refresh_sequencer #(
  parameter int COLUMNS = crls_pkg::COLUMNS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_now_ms,
  input  logic        in_line_sel,
  input  logic [3:0]  in_column,
  input  logic [7:0]  in_char_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_hi_setup,
  output logic [7:0]  out_hi_strobe,
  output logic [7:0]  out_hi_release,
  output logic [7:0]  out_lo_setup,
  output logic [7:0]  out_lo_strobe,
  output logic [7:0]  out_lo_release,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_min_gap_ms
);
  import crls_pkg::*;

  localparam int AW = $clog2(2 * COLUMNS);
  localparam int CW = $clog2(COLUMNS);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_LINE1 = 2'd1;
  localparam logic [1:0] PH_LINE2 = 2'd2;

  seq_stat_t stat;
  seq_ctl_t  ctl;

  logic [7:0]    min_gap_r;
  logic          pending_r, pending_nxt;
  logic [31:0]   last_r;
  logic [1:0]    phase_r, phase_nxt;
  logic          line_r, line_nxt;
  logic [CW-1:0] col_r, col_nxt;

  logic          in_fire, tick_go, col_ok, col_last, out_free;
  logic [31:0]   elapsed;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    rd_data, out_value;

  assign in_ready = ctl.take_in;
  assign in_fire  = in_valid && in_ready;
  assign elapsed  = in_now_ms - last_r;
  assign tick_go  = (in_op == OP_TICK) && pending_r && (elapsed >= {24'd0, min_gap_r});
  assign col_ok   = {28'd0, in_column} < 32'(COLUMNS);
  assign col_last = col_r == CW'(COLUMNS - 1);

  assign stat.in_valid = in_valid;
  assign stat.line_go  = tick_go && (phase_r == PH_LINE1 || phase_r == PH_LINE2);
  assign stat.out_free = out_free;
  assign stat.col_last = col_last;

  crls_sequencer u_seq (
    .clk  (clk),
    .rst_n(rst_n),
    .stat (stat),
    .ctl  (ctl)
  );

  always_comb begin
    pending_nxt = pending_r;
    phase_nxt   = phase_r;
    line_nxt    = line_r;
    if (in_fire) begin
      case (in_op)
        OP_WRITE, OP_REQ: begin
          pending_nxt = 1'b1;
        end
        OP_TICK: begin
          if (tick_go) begin
            case (phase_r)
              PH_LINE1: begin
                phase_nxt = PH_LINE2;
                line_nxt  = 1'b0;
              end
              PH_LINE2: begin
                phase_nxt   = PH_IDLE;
                pending_nxt = 1'b0;
                line_nxt    = 1'b1;
              end
              default: begin
                phase_nxt = PH_LINE1;
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_gap_r <= MIN_GAP_RST;
      pending_r <= 1'b1;
      last_r    <= '0;
      phase_r   <= PH_IDLE;
      line_r    <= 1'b0;
      col_r     <= '0;
    end else begin
      if (cfg_we) min_gap_r <= cfg_min_gap_ms;
      if (in_fire && tick_go) last_r <= in_now_ms;
      pending_r <= pending_nxt;
      phase_r   <= phase_nxt;
      line_r    <= line_nxt;
      col_r     <= col_nxt;
    end
  end

  // The read for the next character goes out while the current one is sent.
  always_comb begin
    col_nxt = col_r;
    if (ctl.load_cmd) begin
      col_nxt = '0;
    end else if (ctl.load_char && !col_last) begin
      col_nxt = col_r + 1'b1;
    end
  end

  assign rd_addr = line_r ? AW'(COLUMNS) + AW'(col_nxt) : AW'(col_nxt);
  assign wr_addr = in_line_sel ? AW'(COLUMNS) + AW'(in_column) : AW'(in_column);

  crls_line_mem #(
    .COLUMNS(COLUMNS),
    .AW     (AW)
  ) u_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (in_fire && (in_op == OP_WRITE) && col_ok),
    .wr_addr(wr_addr),
    .wr_data(in_char_code),
    .rd_en  (ctl.load_cmd || (ctl.load_char && !col_last)),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign out_value = ctl.load_cmd ? (line_r ? CMD_LINE2 : CMD_LINE1) : rd_data;

  crls_out_stage u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (ctl.load_cmd || ctl.load_char),
    .value         (out_value),
    .is_data       (ctl.load_char),
    .fin           (ctl.load_char && col_last),
    .free          (out_free),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_hi_setup  (out_hi_setup),
    .out_hi_strobe (out_hi_strobe),
    .out_hi_release(out_hi_release),
    .out_lo_setup  (out_lo_setup),
    .out_lo_strobe (out_lo_strobe),
    .out_lo_release(out_lo_release),
    .out_last      (out_last)
  );

`ifndef ASSERT_OFF
  a_no_take_while_sending: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !(ctl.load_cmd || ctl.load_char))
    else $error("input taken while a line phase is being sent");

  a_ready_after_line: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.load_char && col_last) |=> in_ready)
    else $error("sequencer did not return to wait after the last character");

  a_phase_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_fire && in_op == OP_TICK) |=> $stable(phase_r))
    else $error("phase moved without an accepted tick");

  a_pending_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (pending_r && !pending_nxt) |-> (phase_r == PH_LINE2))
    else $error("refresh flag cleared outside the second line phase");
`endif

endmodule
